// ===== design/modular_exponentiation_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the modular exponentiation core
// Concurrent assertion wrappers that compile to nothing in synthesis.
// ---------------------------------------------------------------------------
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef MODULAR_EXPONENTIATION_CORE_ASSERT_SVH
`define MODULAR_EXPONENTIATION_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Property checked at every clock edge outside reset.
`define MEXP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define MEXP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MEXP_ASSERT(lbl, prop, msg)
`define MEXP_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== design/mexp_pkg.sv =====
// ---------------------------------------------------------------------------
// Modular exponentiation package
// Shared constants and the sequencer state type.
// ---------------------------------------------------------------------------
package mexp_pkg;

    // Default operand width in bits.
    localparam int MEXP_DATA_WIDTH = 64;

    // Sequencer states of the exponentiation controller.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_REDUCE,
        ST_CHECK,
        ST_MUL,
        ST_SQUARE,
        ST_DONE
    } mexp_state_t;

endpackage

// ===== design/mexp_modmul.sv =====
// ---------------------------------------------------------------------------
// Modular shift-add multiplier
// Computes (addend * multiplier) mod modulus, one multiplier bit per cycle,
// MSB first. Operands are captured on start; done pulses with the product.
// ---------------------------------------------------------------------------
`include "modular_exponentiation_core_assert.svh"

module mexp_modmul
    import mexp_pkg::*;
#(
    parameter int DATA_WIDTH = MEXP_DATA_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] addend,
    input  logic [DATA_WIDTH-1:0] multiplier,
    input  logic [DATA_WIDTH-1:0] modulus,
    output logic                  busy,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] product
);

    localparam int CNT_W = $clog2(DATA_WIDTH);

    logic [DATA_WIDTH-1:0] work_reg,     work_next;
    logic [DATA_WIDTH-1:0] mult_reg,     mult_next;
    logic [DATA_WIDTH-1:0] addend_reg,   addend_next;
    logic [DATA_WIDTH-1:0] modulus_reg,  modulus_next;
    logic [CNT_W-1:0]      count_reg,    count_next;
    logic                  running_reg,  running_next;
    logic                  done_reg,     done_next;

    logic [DATA_WIDTH+1:0] sum;
    logic [DATA_WIDTH+1:0] mod_once;
    logic [DATA_WIDTH+1:0] mod_twice;
    logic [DATA_WIDTH+1:0] step_full;

    // One step: double the partial product and add the addend when the
    // current multiplier bit is set. The sum stays below three moduli, so
    // one of two parallel subtractions brings it back into range.
    always_comb
    begin
        sum       = {1'b0, work_reg, 1'b0}
                  + {2'b00, (mult_reg[DATA_WIDTH-1] ? addend_reg : '0)};
        mod_once  = {2'b00, modulus_reg};
        mod_twice = {1'b0, modulus_reg, 1'b0};
        if (sum >= mod_twice)
        begin
            step_full = sum - mod_twice;
        end
        else if (sum >= mod_once)
        begin
            step_full = sum - mod_once;
        end
        else
        begin
            step_full = sum;
        end
    end

    // Operand capture on start and the per-bit iteration.
    always_comb
    begin
        work_next    = work_reg;
        mult_next    = mult_reg;
        addend_next  = addend_reg;
        modulus_next = modulus_reg;
        count_next   = count_reg;
        running_next = running_reg;
        done_next    = 1'b0;
        if (start)
        begin
            work_next    = '0;
            mult_next    = multiplier;
            addend_next  = addend;
            modulus_next = modulus;
            count_next   = CNT_W'(DATA_WIDTH - 1);
            running_next = 1'b1;
        end
        else if (running_reg)
        begin
            work_next = step_full[DATA_WIDTH-1:0];
            mult_next = {mult_reg[DATA_WIDTH-2:0], 1'b0};
            if (count_reg == CNT_W'(0))
            begin
                running_next = 1'b0;
                done_next    = 1'b1;
            end
            else
            begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            running_reg <= running_next;
            done_reg    <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        work_reg    <= work_next;
        mult_reg    <= mult_next;
        addend_reg  <= addend_next;
        modulus_reg <= modulus_next;
    end

    assign busy    = running_reg;
    assign done    = done_reg;
    assign product = work_reg;

    // A new operation is only started while the unit is idle.
    `MEXP_ASSERT(a_start_when_idle, start |-> !running_reg, "start while busy")
    // Completion is a single-cycle pulse.
    `MEXP_ASSERT_NEXT(a_done_pulse, done_reg, !done_reg, "done held over two cycles")
    // Every finished product is reduced below the modulus.
    `MEXP_ASSERT(a_product_reduced, done_reg |-> (work_reg < modulus_reg),
                 "product not reduced")

endmodule

// ===== design/modular_exponentiation_core.sv =====
// ---------------------------------------------------------------------------
// Modular exponentiation core
// Right-to-left square-and-multiply over a shared modular multiplier.
// ---------------------------------------------------------------------------
// Each request carries a base, an exponent and a modulus, with sign flags for
// the exponent and the modulus. A negative exponent, a zero modulus or a
// negative modulus gives status 1 and a result of 0. Otherwise the base is
// first reduced modulo the modulus, then each exponent bit takes a multiply
// (when the bit is set) and each bit below the top one a square, all on one
// shift-add modular multiplier that retires one operand bit per cycle. An
// exponent of zero returns 1 after the base reduction. One request is in
// flight at a time; the next request is taken while the previous result
// waits in the output register.
`include "modular_exponentiation_core_assert.svh"

module modular_exponentiation_core
    import mexp_pkg::*;
#(
    parameter int DATA_WIDTH = MEXP_DATA_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DATA_WIDTH-1:0] base_value,
    input  logic [DATA_WIDTH-1:0] exponent_value,
    input  logic                  exponent_negative,
    input  logic [DATA_WIDTH-1:0] modulus_value,
    input  logic                  modulus_negative,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] power_result,
    output logic                  status
);

    mexp_state_t           state_reg,    state_next;
    logic [DATA_WIDTH-1:0] acc_reg,      acc_next;
    logic [DATA_WIDTH-1:0] power_reg,    power_next;
    logic [DATA_WIDTH-1:0] exp_reg,      exp_next;
    logic [DATA_WIDTH-1:0] mod_reg,      mod_next;
    logic                  err_reg,      err_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0] result_reg,   result_next;
    logic                  status_reg,   status_next;

    logic                  unit_start;
    logic [DATA_WIDTH-1:0] unit_addend;
    logic                  unit_busy;
    logic                  unit_done;
    logic [DATA_WIDTH-1:0] unit_product;
    logic                  bad_args;

    // Shared modular multiplier; the multiplier operand is always the
    // running power (the base itself during the initial reduction).
    mexp_modmul #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_modmul (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (unit_start),
        .addend     (unit_addend),
        .multiplier (power_reg),
        .modulus    (mod_reg),
        .busy       (unit_busy),
        .done       (unit_done),
        .product    (unit_product)
    );

    assign bad_args = exponent_negative || modulus_negative
                   || (modulus_value == '0);

    // Sequencer: next state, operand selection and result capture.
    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        power_next     = power_reg;
        exp_next       = exp_reg;
        mod_next       = mod_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        status_next    = status_reg;
        unit_start     = 1'b0;
        unit_addend    = power_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    power_next = base_value;
                    exp_next   = exponent_value;
                    mod_next   = modulus_value;
                    acc_next   = DATA_WIDTH'(1);
                    err_next   = bad_args;
                    state_next = bad_args ? ST_DONE : ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                // Base mod modulus as base * 1 mod modulus.
                unit_start  = 1'b1;
                unit_addend = DATA_WIDTH'(1);
                state_next  = ST_REDUCE;
            end
            ST_REDUCE:
            begin
                if (unit_done)
                begin
                    power_next = unit_product;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (exp_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else if (exp_reg[0])
                begin
                    unit_start  = 1'b1;
                    unit_addend = acc_reg;
                    state_next  = ST_MUL;
                end
                else
                begin
                    unit_start = 1'b1;
                    state_next = ST_SQUARE;
                end
            end
            ST_MUL:
            begin
                if (unit_done)
                begin
                    acc_next = unit_product;
                    // The last square is not needed once no exponent bits remain.
                    if (exp_reg[DATA_WIDTH-1:1] == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        unit_start = 1'b1;
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_SQUARE:
            begin
                if (unit_done)
                begin
                    power_next = unit_product;
                    exp_next   = exp_reg >> 1;
                    state_next = ST_CHECK;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    result_next    = err_reg ? '0 : acc_reg;
                    status_next    = err_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        power_reg  <= power_next;
        exp_reg    <= exp_next;
        mod_reg    <= mod_next;
        err_reg    <= err_next;
        result_reg <= result_next;
        status_reg <= status_next;
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign power_result = result_reg;
    assign status       = status_reg;

    // Only one request is in flight at a time.
    `MEXP_ASSERT_NEXT(a_single_request, in_valid && in_ready, !in_ready,
                      "request accepted while another is in flight")
    // The exponent bit test never overlaps a running multiplication.
    `MEXP_ASSERT(a_check_unit_idle, (state_reg == ST_CHECK) |-> !unit_busy,
                 "multiplier busy during exponent check")
    // Leaving the completion state always presents a result.
    `MEXP_ASSERT_NEXT(a_result_loaded,
                      (state_reg == ST_DONE) && (state_next == ST_IDLE),
                      out_valid_reg, "completion without a result")

endmodule
